### sv/olb_pkg.sv
// Shared types and constants for the ordered list buffer.
package olb_pkg;

  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_PREPEND   = 3'd1,
    MODE_DEL_LAST  = 3'd2,
    MODE_DEL_FIRST = 3'd3,
    MODE_DEL_ALL   = 3'd4,
    MODE_READ      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     ins;
  } cell_cmd_t;

endpackage

### sv/olb_cell.sv
// One storage cell of the list chain: holds one entry, trades with its neighbors.
module olb_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  olb_pkg::cell_cmd_t cmd_i,
  input  logic [IW-1:0]      tgt_i,
  input  logic [31:0]        load_i,
  input  logic [31:0]        prev_i,
  input  logic [31:0]        next_i,
  input  logic [31:0]        head_i,
  output logic [31:0]        val_o
);
  import olb_pkg::*;

  logic [31:0] val_d, val_q;
  logic        hit;

  assign hit = (tgt_i == IW'(IDX));

  always_comb begin
    case (cmd_i.op)
      CELL_HOLD: val_d = val_q;
      CELL_LOAD: val_d = hit ? load_i : val_q;
      CELL_UP:   val_d = prev_i;
      CELL_DOWN: val_d = (cmd_i.ins && hit) ? head_i : next_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

### sv/olb_ctrl.sv
// Sequencer for the list chain: count, sweeps for delete-all and read, result beats.
module olb_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [2:0]                            mode_i,
  input  logic [31:0]                           head_i,
  input  logic [31:0]                           value_i,
  output logic                                  busy_o,
  output olb_pkg::cell_cmd_t                    cmd_o,
  output logic [$clog2(CAPACITY)-1:0]           tgt_o,
  output logic                                  out_valid_o,
  output logic [31:0]                           item_value_o,
  output logic [3:0]                            item_index_o,
  output logic [4:0]                            entry_count_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);
  import olb_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e        state_d, state_q;
  logic [CW-1:0] count_d, count_q;
  logic [CW-1:0] live_d, live_q;
  logic [CW-1:0] rem_d, rem_q;
  logic          read_d, read_q;
  logic          emit_d, emit_q;
  logic [3:0]    ecnt_d, ecnt_q;
  logic [3:0]    nlast_d, nlast_q;
  logic [31:0]   match_d, match_q;

  logic          ov_d;
  logic [31:0]   iv_d;
  logic [3:0]    ii_d;
  logic [4:0]    ec_d;
  status_e       st_d, st_q;
  logic          last_d;

  logic          accept;
  logic          keep;
  logic [CW-1:0] cm1;

  assign accept = start_i && (state_q == S_IDLE);
  assign keep   = read_q || (head_i != match_q);
  assign cm1    = count_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && count_q != '0 &&
            (mode_i == MODE_DEL_ALL || mode_i == MODE_READ)) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (rem_q == CW'(1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result beat
  always_comb begin
    count_d = count_q;
    live_d  = live_q;
    rem_d   = rem_q;
    read_d  = read_q;
    emit_d  = emit_q;
    ecnt_d  = ecnt_q;
    nlast_d = nlast_q;
    match_d = match_q;
    cmd_o   = '{op: CELL_HOLD, ins: 1'b0};
    tgt_o   = IW'(count_q);
    ov_d    = 1'b0;
    iv_d    = '0;
    ii_d    = '0;
    ec_d    = 5'(count_q);
    st_d    = ST_OK;
    last_d  = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ov_d = 1'b1;
          case (mode_i)
            MODE_APPEND: begin
              if (count_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                cmd_o.op = CELL_LOAD;
                count_d  = count_q + CW'(1);
                ec_d     = 5'(count_d);
              end
            end
            MODE_PREPEND: begin
              if (count_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                cmd_o.op = CELL_UP;
                count_d  = count_q + CW'(1);
                ec_d     = 5'(count_d);
              end
            end
            MODE_DEL_LAST: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                count_d = cm1;
                ec_d    = 5'(cm1);
              end
            end
            MODE_DEL_FIRST: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                cmd_o.op = CELL_DOWN;
                count_d  = cm1;
                ec_d     = 5'(cm1);
              end
            end
            MODE_DEL_ALL, MODE_READ: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                // result beats come out of the sweep
                ov_d    = 1'b0;
                rem_d   = count_q;
                live_d  = count_q;
                read_d  = (mode_i == MODE_READ);
                emit_d  = (mode_i == MODE_READ);
                ecnt_d  = '0;
                match_d = value_i;
                nlast_d = (32'(count_q) > MAX_RESULTS) ? 4'(MAX_RESULTS - 1) : 4'(cm1);
              end
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        // head leaves; kept entries rotate in behind the live region
        cmd_o.op  = CELL_DOWN;
        cmd_o.ins = keep;
        tgt_o     = IW'(live_q - CW'(1));
        live_d    = keep ? live_q : live_q - CW'(1);
        rem_d     = rem_q - CW'(1);
        if (emit_q) begin
          ov_d   = 1'b1;
          iv_d   = head_i;
          ii_d   = ecnt_q;
          last_d = (ecnt_q == nlast_q);
          ecnt_d = ecnt_q + 4'd1;
          emit_d = (ecnt_q != nlast_q);
        end
        if (rem_q == CW'(1)) begin
          count_d = live_d;
          if (!read_q) begin
            ov_d = 1'b1;
            ec_d = 5'(live_d);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      emit_q      <= emit_d;
      out_valid_o <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    live_q        <= live_d;
    read_q        <= read_d;
    ecnt_q        <= ecnt_d;
    nlast_q       <= nlast_d;
    match_q       <= match_d;
    item_value_o  <= iv_d;
    item_index_o  <= ii_d;
    entry_count_o <= ec_d;
    st_q          <= st_d;
    last_o        <= last_d;
  end

  assign status_o = st_q;
  assign busy_o   = (state_q == S_SWEEP);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");

  a_sweep_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> rem_q != '0)
    else $error("sweep running with nothing left");

  a_live_ge_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> (live_q >= rem_q && live_q <= count_q))
    else $error("live count out of step with sweep");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i != MODE_DEL_ALL && mode_i != MODE_READ) |=>
      (out_valid_o && last_o && state_q == S_IDLE))
    else $error("single-beat op gave no final beat");

  a_sweep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && rem_q == CW'(1) && !read_q) |=> (out_valid_o && last_o))
    else $error("delete-all finished without a result beat");

endmodule

### sv/ordered_list_buffer_with_match_delete.sv
// Ordered list buffer: a start/busy command port, a strobed result port.
//
// An operation is taken at a clock edge with start_i high and busy_o low.
// mode_i picks append, prepend, delete last, delete first, delete all equal
// or read all; value_i is the value to insert or to match.
// Entries live in a chain of CAPACITY cells that shift as one row.
// Insert, delete last/first and unknown modes finish in the cycle they are
// taken: one result beat with last_o set appears the next cycle and busy_o
// stays low, so a new operation can follow every cycle.
// Delete all equal and read all sweep the chain, one entry per cycle,
// rotating kept entries back in behind the live region: busy_o is high for
// entry_count cycles. Read all gives one beat per entry, the first two cycles
// after it is taken (at most 16 beats); delete all gives one beat after the
// sweep ends. An empty list answers either with a single beat at once.
// A beat is on the outputs for one cycle only, marked by out_valid_o; the
// receiver cannot stall it.
// Reset empties the list; entry storage itself is not cleared.
module ordered_list_buffer_with_match_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  output logic [31:0] item_value_o,
  output logic [3:0]  item_index_o,
  output logic [4:0]  entry_count_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import olb_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  cell_cmd_t     cmd;
  logic [IW-1:0] tgt;
  logic [31:0]   cell_val [CAPACITY];

  olb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .mode_i        (mode_i),
    .head_i        (cell_val[0]),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .cmd_o         (cmd),
    .tgt_o         (tgt),
    .out_valid_o   (out_valid_o),
    .item_value_o  (item_value_o),
    .item_index_o  (item_index_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] prev_val, next_val;
    if (i == 0) begin : g_first
      assign prev_val = value_i;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end
    olb_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .tgt_i  (tgt),
      .load_i (value_i),
      .prev_i (prev_val),
      .next_i (next_val),
      .head_i (cell_val[0]),
      .val_o  (cell_val[i])
    );
  end

endmodule
